@@ hw/rtl/tabular_q_learning_update_defines.svh @@
// ----------------------------------------------------------------------------
// tabular q-learning update: assertion macros
// shared check macros, clocked on i_clk and masked while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef TABULAR_Q_LEARNING_UPDATE_DEFINES_SVH
`define TABULAR_Q_LEARNING_UPDATE_DEFINES_SVH

// same-cycle implication
`define QLU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qlu check failed");

// next-cycle implication
`define QLU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qlu check failed");

`endif

@@ hw/rtl/qlu_pkg.sv @@
// ----------------------------------------------------------------------------
// qlu_pkg
// shared sizes, codes, types and address helper for the q-learning update
// ----------------------------------------------------------------------------
`default_nettype none

package qlu_pkg;

    // table geometry
    localparam int GRID_WIDTH  = 30;
    localparam int GRID_HEIGHT = 20;
    localparam int SITUATIONS  = 256;
    localparam int ACTIONS     = 4;

    localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
    localparam int ROWS   = CELLS * SITUATIONS;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SIT_W  = $clog2(SITUATIONS);
    localparam int ROW_W  = $clog2(ROWS);

    // field widths
    localparam int COORD_W   = 7;
    localparam int SITCODE_W = 8;
    localparam int ACT_W     = 2;
    localparam int Q_W       = 32;
    localparam int RATE_W    = 16;
    localparam int FRAC_W    = 16;
    localparam int POS_W     = COORD_W + $clog2(GRID_WIDTH + 1) + 1;

    // arithmetic widths
    localparam int TD_W       = Q_W + 2;
    localparam int PROD1_W    = RATE_W + 1 + Q_W - 1;
    localparam int PROD2_W    = RATE_W + 1 + TD_W;
    localparam int STEP_W     = PROD2_W - FRAC_W;
    localparam int SUM_W      = STEP_W + 1;
    localparam int ROUND_HALF = 1 << (FRAC_W - 1);

    // stream words
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 72;

    // opcodes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // configuration registers
    localparam int   CFG_IDX_W     = 1;
    localparam logic REG_STEP_SIZE = 1'b0;
    localparam logic REG_DISCOUNT  = 1'b1;
    localparam logic [RATE_W-1:0] LR_RESET = 16'd6554;
    localparam logic [RATE_W-1:0] DF_RESET = 16'd64881;

    typedef logic [ROW_W-1:0] t_row;
    typedef logic [ACT_W-1:0] t_act;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load_in;
        logic ld_addr;
        logic ld_max;
        logic ld_mul1;
        logic ld_td;
        logic ld_mul2;
        logic ld_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_query;
        logic clr_last;
        logic out_free;
    } t_sts;

    // row of (clamped position, clamped situation)
    function automatic t_row row_of(input logic signed [COORD_W-1:0] x,
                                    input logic signed [COORD_W-1:0] y,
                                    input logic [SITCODE_W-1:0] s);
        logic signed [POS_W-1:0] pos;
        logic [CELL_W-1:0]       cell_no;
        logic [SIT_W-1:0]        sit;
        pos = POS_W'(y) * POS_W'(GRID_WIDTH) + POS_W'(x);
        if (pos < 0) begin
            cell_no = '0;
        end else if (pos >= POS_W'(CELLS)) begin
            cell_no = CELL_W'(CELLS - 1);
        end else begin
            cell_no = CELL_W'(pos);
        end
        if ({1'b0, s} >= (SITCODE_W + 1)'(SITUATIONS)) begin
            sit = SIT_W'(SITUATIONS - 1);
        end else begin
            sit = SIT_W'(s);
        end
        return ROW_W'(cell_no) * ROW_W'(SITUATIONS) + ROW_W'(sit);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/qlu_ram.sv @@
// ----------------------------------------------------------------------------
// qlu_ram
// one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module qlu_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    output logic      [WIDTH-1:0] o_rdata_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

@@ hw/rtl/qlu_ctrl.sv @@
// ----------------------------------------------------------------------------
// qlu_ctrl
// sequencer: clearing pass, then one word at a time through the datapath
// ----------------------------------------------------------------------------
`default_nettype none

module qlu_ctrl
    import qlu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_valid,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_s_ready
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ADDR  = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_MAX   = 4'd4;
    localparam logic [3:0] S_MUL1  = 4'd5;
    localparam logic [3:0] S_TD    = 4'd6;
    localparam logic [3:0] S_MUL2  = 4'd7;
    localparam logic [3:0] S_WRITE = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE:  if (i_s_valid) n_state = S_ADDR;
            S_ADDR:  n_state = S_READ;
            S_READ:  n_state = S_MAX;
            S_MAX:   n_state = i_sts.is_query ? S_WRITE : S_MUL1;
            S_MUL1:  n_state = S_TD;
            S_TD:    n_state = S_MUL2;
            S_MUL2:  n_state = S_WRITE;
            S_WRITE: if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    assign o_s_ready        = (r_state == S_IDLE);
    assign o_cmd.clr_step   = (r_state == S_CLEAR);
    assign o_cmd.load_in    = (r_state == S_IDLE) && i_s_valid;
    assign o_cmd.ld_addr    = (r_state == S_ADDR);
    assign o_cmd.ld_max     = (r_state == S_MAX);
    assign o_cmd.ld_mul1    = (r_state == S_MUL1);
    assign o_cmd.ld_td      = (r_state == S_TD);
    assign o_cmd.ld_mul2    = (r_state == S_MUL2);
    assign o_cmd.ld_out     = (r_state == S_WRITE) && i_sts.out_free;

endmodule

`default_nettype wire

@@ hw/rtl/qlu_dp.sv @@
// ----------------------------------------------------------------------------
// qlu_dp
// value banks, greedy search, fixed-point update arithmetic, output register
// ----------------------------------------------------------------------------
`default_nettype none

module qlu_dp
    import qlu_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    input  wire logic [IN_DATA_W-1:0]  i_s_data,
    input  wire logic                  i_s_user,
    output logic                       o_m_valid,
    input  wire logic                  i_m_ready,
    output logic [OUT_DATA_W-1:0]      o_m_data,
    output logic                       o_m_user,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [RATE_W-1:0]     i_cfg_data
);

    // input word fields
    logic signed [COORD_W-1:0] w_old_x, w_old_y, w_new_x, w_new_y;
    logic [SITCODE_W-1:0]      w_old_sit, w_new_sit;
    logic [ACT_W-1:0]          w_act_in;
    logic [Q_W-1:0]            w_reward;

    assign w_old_x   = i_s_data[6:0];
    assign w_old_y   = i_s_data[13:7];
    assign w_old_sit = i_s_data[21:14];
    assign w_act_in  = i_s_data[23:22];
    assign w_reward  = i_s_data[55:24];
    assign w_new_x   = i_s_data[62:56];
    assign w_new_y   = i_s_data[69:63];
    assign w_new_sit = i_s_data[77:70];

    // configuration
    logic [RATE_W-1:0] r_lr;
    logic [RATE_W-1:0] r_df;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr <= LR_RESET;
            r_df <= DF_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_STEP_SIZE: r_lr <= i_cfg_data;
                REG_DISCOUNT:  r_df <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // captured item
    logic                      r_op;
    t_act                      r_act;
    logic signed [Q_W-1:0]     r_reward;
    logic signed [COORD_W-1:0] r_old_x, r_old_y, r_new_x, r_new_y;
    logic [SITCODE_W-1:0]      r_old_sit, r_new_sit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op      <= i_s_user;
            r_reward  <= w_reward;
            r_old_x   <= w_old_x;
            r_old_y   <= w_old_y;
            r_old_sit <= w_old_sit;
            r_new_x   <= w_new_x;
            r_new_y   <= w_new_y;
            r_new_sit <= w_new_sit;
            if ({1'b0, w_act_in} >= (ACT_W + 1)'(ACTIONS)) begin
                r_act <= ACT_W'(ACTIONS - 1);
            end else begin
                r_act <= w_act_in;
            end
        end
    end

    // row addresses
    t_row r_old_row;
    t_row r_grd_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_addr) begin
            r_old_row <= row_of(r_old_x, r_old_y, r_old_sit);
            r_grd_row <= (r_op == OP_QUERY) ? row_of(r_old_x, r_old_y, r_old_sit)
                                            : row_of(r_new_x, r_new_y, r_new_sit);
        end
    end

    // clearing pass counter
    t_row r_clr_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_row <= r_clr_row + ROW_W'(1);
        end
    end

    // one bank per action
    logic [ACTIONS-1:0] w_we;
    t_row               w_waddr;
    logic [Q_W-1:0]     w_wdata;
    logic [Q_W-1:0]     w_rd_grd [ACTIONS];
    logic [Q_W-1:0]     w_rd_old [ACTIONS];
    logic signed [Q_W-1:0] w_new_val;

    assign w_waddr = i_cmd.clr_step ? r_clr_row : r_old_row;
    assign w_wdata = i_cmd.clr_step ? '0 : w_new_val;

    for (genvar k = 0; k < ACTIONS; k++) begin : g_bank
        assign w_we[k] = i_cmd.clr_step
                       | (i_cmd.ld_out & (r_op == OP_UPDATE) & (r_act == ACT_W'(k)));

        qlu_ram #(
            .DEPTH (ROWS),
            .WIDTH (Q_W)
        ) u_ram (
            .i_clk     (i_clk),
            .i_we      (w_we[k]),
            .i_waddr   (w_waddr),
            .i_wdata   (w_wdata),
            .i_raddr_a (r_grd_row),
            .o_rdata_a (w_rd_grd[k]),
            .i_raddr_b (r_old_row),
            .o_rdata_b (w_rd_old[k])
        );
    end

    // greedy search, first maximum wins
    logic signed [Q_W-1:0] w_max_val;
    t_act                  w_max_act;
    logic signed [Q_W-1:0] w_old_val;

    always_comb begin
        w_max_val = w_rd_grd[0];
        w_max_act = '0;
        for (int k = 1; k < ACTIONS; k++) begin
            if ($signed(w_rd_grd[k]) > w_max_val) begin
                w_max_val = w_rd_grd[k];
                w_max_act = ACT_W'(k);
            end
        end
    end

    always_comb begin
        w_old_val = w_rd_old[0];
        for (int k = 1; k < ACTIONS; k++) begin
            if (r_act == ACT_W'(k)) w_old_val = w_rd_old[k];
        end
    end

    logic signed [Q_W-1:0] r_best;
    t_act                  r_best_act;
    logic signed [Q_W-1:0] r_old_val;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_max) begin
            r_best     <= w_max_val;
            r_best_act <= w_max_act;
            r_old_val  <= w_old_val;
        end
    end

    // discounted max
    logic signed [PROD1_W-1:0] r_prod1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_mul1) begin
            r_prod1 <= $signed({1'b0, r_df}) * r_best;
        end
    end

    // temporal difference
    logic signed [PROD1_W-1:0] w_sum1;
    logic signed [Q_W-1:0]     w_disc;
    logic signed [TD_W-1:0]    r_td;

    assign w_sum1 = r_prod1 + PROD1_W'(ROUND_HALF);
    assign w_disc = Q_W'(w_sum1 >>> FRAC_W);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_td) begin
            r_td <= TD_W'(r_reward) + TD_W'(w_disc) - TD_W'(r_old_val);
        end
    end

    // scaled step
    logic signed [PROD2_W-1:0] r_prod2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_mul2) begin
            r_prod2 <= $signed({1'b0, r_lr}) * r_td;
        end
    end

    // new value with saturation
    logic signed [PROD2_W-1:0] w_sum2;
    logic signed [STEP_W-1:0]  w_step;
    logic signed [SUM_W-1:0]   w_nv;
    logic                      w_sat;

    assign w_sum2 = r_prod2 + PROD2_W'(ROUND_HALF);
    assign w_step = STEP_W'(w_sum2 >>> FRAC_W);
    assign w_nv   = SUM_W'(r_old_val) + SUM_W'(w_step);
    assign w_sat  = !((&w_nv[SUM_W-1:Q_W-1]) || !(|w_nv[SUM_W-1:Q_W-1]));

    always_comb begin
        if (!w_sat) begin
            w_new_val = w_nv[Q_W-1:0];
        end else if (w_nv[SUM_W-1]) begin
            w_new_val = {1'b1, {(Q_W - 1){1'b0}}};
        end else begin
            w_new_val = {1'b0, {(Q_W - 1){1'b1}}};
        end
    end

    // output register
    logic           r_out_valid;
    t_act           r_out_act;
    logic [Q_W-1:0] r_out_best;
    logic [Q_W-1:0] r_out_written;
    logic           r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_out_act  <= r_best_act;
            r_out_best <= r_best;
            if (r_op == OP_QUERY) begin
                r_out_written <= '0;
                r_out_sat     <= 1'b0;
            end else begin
                r_out_written <= w_new_val;
                r_out_sat     <= w_sat;
            end
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = {{(OUT_DATA_W - ACT_W - 2 * Q_W){1'b0}},
                        r_out_written, r_out_best, r_out_act};
    assign o_m_user  = r_out_sat;

    assign o_sts.is_query = (r_op == OP_QUERY);
    assign o_sts.clr_last = (r_clr_row == ROW_W'(ROWS - 1));
    assign o_sts.out_free = !r_out_valid || i_m_ready;

endmodule

`default_nettype wire

@@ hw/rtl/tabular_q_learning_update.sv @@
// ----------------------------------------------------------------------------
// tabular_q_learning_update
// q-value table with temporal-difference update and greedy action query
// ----------------------------------------------------------------------------
// The table holds one signed Q16.16 value per (grid cell, situation, action),
// kept in one memory bank per action so the four action values of a row come
// out in one read. After reset the block runs a clearing pass that writes
// zero to every row, one row a cycle, during which no word is accepted;
// configuration writes are taken at any time. After that one word is worked
// on at a time by a sequencer: an update passes through address, bank read,
// greedy compare, discount multiply, td sum, learning-rate multiply and write
// states, its result being loaded into the output register in the write state
// once that register is free; a query skips the multiplies and the td sum. The
// next word is accepted in the cycle after the result is loaded, even while
// that result still waits for the sink, so no new word is taken before the
// last one's result is loaded.
`default_nettype none

`include "tabular_q_learning_update_defines.svh"

module tabular_q_learning_update
    import qlu_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // input words
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // old_x[6:0], old_y[13:7], old_situation[21:14], taken_action[23:22],
    // reward[55:24], new_x[62:56], new_y[69:63], new_situation[77:70], zero
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // opcode[0]
    input  wire logic                  i_s_axis_tuser,

    // result words
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // best_action[1:0], best_value[33:2], written_value[65:34], zero
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    // saturated[0]
    output logic                       o_m_axis_tuser,

    // register writes: index 0 step size alpha, index 1 discount gamma
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [RATE_W-1:0]     i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    // register writes never stall
    assign o_cfg_ready = 1'b1;

    // sequencer: clearing pass, then idle / address / read / max /
    // multiply / td / multiply / write
    qlu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd),
        .o_s_ready (o_s_axis_tready)
    );

    // banks, arithmetic and the output register
    qlu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_s_data    (i_s_axis_tdata),
        .i_s_user    (i_s_axis_tuser),
        .o_m_valid   (o_m_axis_tvalid),
        .i_m_ready   (i_m_axis_tready),
        .o_m_data    (o_m_axis_tdata),
        .o_m_user    (o_m_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // a result is only loaded into a free output slot
    `QLU_ASSERT_IMP(a_out_slot_free, w_cmd.ld_out, w_sts.out_free)
    // no word is taken during the clearing pass
    `QLU_ASSERT_IMP(a_no_accept_in_clear, w_cmd.clr_step, !o_s_axis_tready)
    // one word in flight at a time
    `QLU_ASSERT_NXT(a_one_in_flight, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    // a loaded result is offered in the next cycle
    `QLU_ASSERT_NXT(a_result_offered, w_cmd.ld_out, o_m_axis_tvalid)

endmodule

`default_nettype wire
